@@ hdl/acmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_pkg
// Shared constants, types and the symbol decoder of the column consensus block.
// ----------------------------------------------------------------------------
package acmc_pkg;

  // sizing
  localparam int MAX_COLUMNS   = 4096;
  localparam int MAX_SEQUENCES = 255;
  localparam int NUM_CLASSES   = 5;

  // fixed field widths
  localparam int COL_W  = 12;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 2;

  // derived widths
  localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEQUENCES + 1);
  localparam int WORD_W = NUM_CLASSES * CNT_W;

  // item operations
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_VOTE = 1'b1
  } opcode_t;

  // counter classes, in vote priority order
  typedef logic [2:0] class_t;
  localparam class_t CLS_A   = 3'd0;
  localparam class_t CLS_T   = 3'd1;
  localparam class_t CLS_G   = 3'd2;
  localparam class_t CLS_C   = 3'd3;
  localparam class_t CLS_GAP = 3'd4;

  // alignment characters
  localparam logic [SYM_W-1:0] CHR_A_UP = 8'h41;
  localparam logic [SYM_W-1:0] CHR_A_LO = 8'h61;
  localparam logic [SYM_W-1:0] CHR_T_UP = 8'h54;
  localparam logic [SYM_W-1:0] CHR_T_LO = 8'h74;
  localparam logic [SYM_W-1:0] CHR_G_UP = 8'h47;
  localparam logic [SYM_W-1:0] CHR_G_LO = 8'h67;
  localparam logic [SYM_W-1:0] CHR_C_UP = 8'h43;
  localparam logic [SYM_W-1:0] CHR_C_LO = 8'h63;
  localparam logic [SYM_W-1:0] CHR_GAP  = 8'h2d;

  typedef struct packed {
    logic   hit;
    class_t cls;
  } sym_class_t;

  // item held in the update stage
  typedef struct packed {
    logic              valid;
    logic              opcode;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [SYM_W-1:0]  symbol;
  } stage_t;

  // counter word write back
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } wr_t;

  // vote outcome
  typedef struct packed {
    logic              has_base;
    logic [CODE_W-1:0] base_code;
  } vote_t;

  // map a character to its counter class
  function automatic sym_class_t symbol_class(input logic [SYM_W-1:0] sym);
    sym_class_t r;
    r.hit = 1'b1;
    r.cls = CLS_A;
    unique case (sym) inside
      CHR_A_UP, CHR_A_LO: r.cls = CLS_A;
      CHR_T_UP, CHR_T_LO: r.cls = CLS_T;
      CHR_G_UP, CHR_G_LO: r.cls = CLS_G;
      CHR_C_UP, CHR_C_LO: r.cls = CLS_C;
      CHR_GAP:            r.cls = CLS_GAP;
      default:            r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/acmc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc channel interfaces
// Valid/ready channels for input items and vote results.
// ----------------------------------------------------------------------------
interface acmc_item_if import acmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [COL_W-1:0] column;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output opcode, output column, output symbol,
                  input ready);
  modport sink   (input valid, input opcode, input column, input symbol,
                  output ready);
endinterface

interface acmc_result_if import acmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] base_code;
  logic              has_base;

  modport source (output valid, output base_code, output has_base, input ready);
  modport sink   (input valid, input base_code, input has_base, output ready);
endinterface

@@ hdl/acmc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module acmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/acmc_count_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_count_unit
// Modify step: bumps one saturating counter or votes and clears the column.
// ----------------------------------------------------------------------------
module acmc_count_unit import acmc_pkg::*; (
  input  stage_t            stage,
  input  logic [WORD_W-1:0] word,
  output wr_t               wr,
  output vote_t             vote
);

  logic [CNT_W-1:0]  cnt [NUM_CLASSES];
  logic [CNT_W-1:0]  best;
  logic              win_hit;
  class_t            win_cls;
  sym_class_t        sc;
  logic [WORD_W-1:0] word_new;

  always_comb begin
    // unpack the counters
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cnt[i] = word[i*CNT_W +: CNT_W];
    end

    // first strictly largest counter
    best    = '0;
    win_hit = 1'b0;
    win_cls = CLS_A;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (cnt[i] > best) begin
        best    = cnt[i];
        win_hit = 1'b1;
        win_cls = class_t'(i);
      end
    end

    // new counter word
    sc       = symbol_class(stage.symbol);
    word_new = word;
    if (stage.opcode == OP_VOTE) begin
      word_new = '0;
    end else if (sc.hit && (cnt[sc.cls] < CNT_W'(MAX_SEQUENCES))) begin
      word_new[int'(sc.cls)*CNT_W +: CNT_W] = CNT_W'(cnt[sc.cls] + 1'b1);
    end

    wr.we   = stage.valid && stage.in_range && ((stage.opcode == OP_VOTE) || sc.hit);
    wr.addr = stage.addr;
    wr.data = word_new;

    // a base only when a base class wins in a valid column
    vote.has_base  = stage.in_range && win_hit && (win_cls != CLS_GAP);
    vote.base_code = vote.has_base ? win_cls[CODE_W-1:0] : '0;
  end

endmodule

@@ hdl/alignment_column_majority_consensus.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alignment_column_majority_consensus
// Majority consensus over alignment columns with per-column base counters.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready sink; opcode 0 adds symbol to column, opcode 1 votes
//            on column and clears it
//   result : valid/ready source; one transfer per vote item, none per add
// Each column is one 40-bit word (five 8-bit counters) in a 4096-entry RAM.
// An item reads its word at acceptance, the next cycle modifies and writes it
// back; a write from the previous cycle is forwarded to a read of the same
// column, so add items go back to back at one per cycle while ready is high.
// A vote result passes through the update stage and then the result register,
// and can transfer once result.valid is high.
// Adds are taken one per cycle while ready is high; a vote occupies the update
// stage, and no new item is taken while it is there.
// Reset: a clearing pass writes zero to every column, one per cycle; ready
// stays low for its duration.
// Stall: the result register holds while result.ready is low, and no new item
// is taken until it can drain, so nothing is lost.
// ----------------------------------------------------------------------------
module alignment_column_majority_consensus import acmc_pkg::*; (
  input logic           clk,
  input logic           rst,
  acmc_item_if.sink     item,
  acmc_result_if.source result
);

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  stage_t            s1;
  wr_t               wr;
  wr_t               wr_q;
  vote_t             vote;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] cur_word;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              accept;

  // input handshake
  assign item.ready = !clearing && !(s1.valid && (s1.opcode == OP_VOTE))
                      && (!result.valid || result.ready);
  assign accept     = item.valid && item.ready;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MAX_COLUMNS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // update stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= accept;
    end
    s1.opcode   <= item.opcode;
    s1.in_range <= 32'(item.column) < 32'(MAX_COLUMNS);
    s1.addr     <= ADDR_W'(item.column);
    s1.symbol   <= item.symbol;
  end

  // counter memory
  assign ram_we    = clearing || wr.we;
  assign ram_waddr = clearing ? clr_addr : wr.addr;
  assign ram_wdata = clearing ? '0 : wr.data;

  acmc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_COLUMNS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ADDR_W'(item.column)),
    .rdata (ram_rdata)
  );

  // forward last cycle's write over the stale read
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q.we <= 1'b0;
    end else begin
      wr_q.we <= wr.we;
    end
    wr_q.addr <= wr.addr;
    wr_q.data <= wr.data;
  end

  assign cur_word = (wr_q.we && (wr_q.addr == s1.addr)) ? wr_q.data : ram_rdata;

  acmc_count_unit u_count (
    .stage (s1),
    .word  (cur_word),
    .wr    (wr),
    .vote  (vote)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1.valid && (s1.opcode == OP_VOTE)) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (s1.valid && (s1.opcode == OP_VOTE)) begin
      result.base_code <= vote.base_code;
      result.has_base  <= vote.has_base;
    end
  end

  // a transferred vote shows its result after the update stage and result register
  assert property (@(posedge clk) disable iff (rst)
    (accept && (item.opcode == OP_VOTE)) |=> ##1 result.valid)
    else $error("vote result missing");

  // an add never raises a result
  assert property (@(posedge clk) disable iff (rst)
    (s1.valid && (s1.opcode == OP_ADD) && !result.valid) |=> !result.valid)
    else $error("add produced a result");

  // no item is in flight during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1.valid && !wr.we)
    else $error("item overlaps clearing pass");

endmodule
